// File: rtl/core/bfa_pkg.sv
// Shared types and codes for the bitmap frame allocator.
package bfa_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_MARK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOMEM = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_FIRST = 2'd0;
  localparam logic [1:0] CFG_RANGE_LIMIT = 2'd1;

  // Frame numbers are 16 bits wide, so the searchable space is 2^16 frames
  localparam int unsigned FRAME_SPACE = 65536;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] run_start;
    logic [16:0] frame_count;
  } in_word_t;

  typedef struct packed {
    logic [15:0] found_frame;
    logic        status;
  } out_word_t;

endpackage

// File: rtl/core/bfa_ram.sv
// Generic single-port RAM with registered read data.
module bfa_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bitmap_frame_allocator.sv
// Bitmap first-fit frame allocator: one usage bit per frame held in a line-wide RAM.
//
// The usage bitmap lives in a single-port RAM of BITS_PER_LINE-bit lines
// (BITS_PER_LINE must be a power of two). After reset a clearing pass writes
// every line to zero, one line per cycle, ceil(min(FRAME_COUNT,65536)/
// BITS_PER_LINE) lines (1024 at the defaults); no word is accepted during it,
// though configuration writes are. An allocate scans the map one line per
// cycle from range_first while the lines it meets are free; each used frame
// met inside the scanned window holds the scan on its line while the run
// restarts just past it. Frames past the stored map are free and are settled
// without a RAM read. A hit then marks its run with a read-modify-write
// (S_MRD, then S_MWR) per touched line, as free and mark words do. One word is
// worked at a time; a finished result waits in the output register while the
// next word is accepted.
module bitmap_frame_allocator #(
  parameter int FRAME_COUNT   = 65536,
  parameter int BITS_PER_LINE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfa_pkg::in_word_t   in_data_i,
  // Result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfa_pkg::out_word_t  out_data_o,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i
);

  localparam int EffFrames = (FRAME_COUNT < 65536) ? FRAME_COUNT : 65536;
  localparam int Lines     = (EffFrames + BITS_PER_LINE - 1) / BITS_PER_LINE;
  localparam int AddrW     = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int Lb        = $clog2(BITS_PER_LINE);
  localparam int OffW      = Lb + 1;
  localparam int PosW      = 18;

  localparam logic [PosW-1:0]  EffFramesV = PosW'(EffFrames);
  localparam logic [PosW-1:0]  LineBytesV = PosW'(BITS_PER_LINE);
  localparam logic [PosW-1:0]  SpaceV     = PosW'(bfa_pkg::FRAME_SPACE);
  localparam logic [AddrW-1:0] LastLine   = AddrW'(Lines - 1);
  localparam logic [OffW-1:0]  FullOff    = OffW'(BITS_PER_LINE);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_START, S_ASCAN, S_MRD, S_MWR, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [16:0]        first_q, first_d;
  logic [16:0]        limit_q, limit_d;
  bfa_pkg::in_word_t  req_q, req_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    cand_q, cand_d;
  logic [PosW-1:0]    run_q, run_d;
  logic [PosW-1:0]    count_q, count_d;
  logic [PosW-1:0]    lim_q, lim_d;
  logic [PosW-1:0]    hi_q, hi_d;
  logic               set_q, set_d;
  bfa_pkg::out_word_t res_q, res_d;
  logic               out_valid_q, out_valid_d;
  bfa_pkg::out_word_t out_q, out_d;

  logic                     ram_we, ram_re;
  logic [AddrW-1:0]         ram_addr;
  logic [BITS_PER_LINE-1:0] ram_wdata, ram_rdata;

  // Line geometry around the current position
  logic [PosW-1:0]          base, line_end, e_abs, gap, sum, hi_run, hi_eff, lim_eff;
  logic [Lb-1:0]            s_off, u_off;
  logic [OffW-1:0]          lim_off, hi_off;
  logic [BITS_PER_LINE-1:0] avail, used_m, mark_m;
  logic                     any_used, in_virt;

  bfa_ram #(
    .Width (BITS_PER_LINE),
    .Depth (Lines),
    .AddrW (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Masks and first used bit within the current line
  always_comb begin
    base     = pos_q & ~(LineBytesV - PosW'(1));
    line_end = base + LineBytesV;
    s_off    = pos_q[Lb-1:0];
    lim_off  = (lim_q >= line_end) ? FullOff : OffW'(lim_q - base);
    hi_off   = (hi_q >= line_end) ? FullOff : OffW'(hi_q - base);
    e_abs    = (line_end < lim_q) ? line_end : lim_q;
    in_virt  = (pos_q >= EffFramesV);
    for (int j = 0; j < BITS_PER_LINE; j++) begin
      avail[j]  = (OffW'(j) >= {1'b0, s_off}) && (OffW'(j) < lim_off);
      mark_m[j] = (OffW'(j) >= {1'b0, s_off}) && (OffW'(j) < hi_off);
    end
    used_m   = ram_rdata & avail;
    any_used = |used_m;
    u_off    = '0;
    for (int j = BITS_PER_LINE - 1; j >= 0; j--) begin
      if (used_m[j]) begin
        u_off = Lb'(j);
      end
    end
    if (in_virt) begin
      gap = lim_q - pos_q;
    end else if (any_used) begin
      gap = PosW'(u_off - s_off);
    end else begin
      gap = e_abs - pos_q;
    end
    sum     = run_q + gap;
    hi_run  = cand_q + count_q;
    hi_eff  = (hi_run < EffFramesV) ? hi_run : EffFramesV;
    lim_eff = ({1'b0, limit_q} > SpaceV) ? SpaceV : {1'b0, limit_q};
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    first_d     = first_q;
    limit_d     = limit_q;
    req_d       = req_q;
    pos_d       = pos_q;
    cand_d      = cand_q;
    run_d       = run_q;
    count_d     = count_q;
    lim_d       = lim_q;
    hi_d        = hi_q;
    set_d       = set_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = pos_q[Lb +: AddrW];
    ram_wdata   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        bfa_pkg::CFG_RANGE_FIRST: first_d = cfg_data_i;
        bfa_pkg::CFG_RANGE_LIMIT: limit_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AddrW'(1);
        if (clr_q == LastLine) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_START;
        end
      end
      S_START: begin
        res_d   = '{found_frame: '0, status: bfa_pkg::STATUS_OK};
        state_d = S_DONE;
        count_d = {1'b0, req_q.frame_count};
        case (req_q.kind)
          bfa_pkg::KIND_ALLOC: begin
            if (req_q.frame_count == '0) begin
              res_d.found_frame = first_q[15:0];
            end else if ({1'b0, first_q} >= lim_eff) begin
              res_d.status = bfa_pkg::STATUS_NOMEM;
            end else begin
              pos_d    = {1'b0, first_q};
              cand_d   = {1'b0, first_q};
              run_d    = '0;
              lim_d    = lim_eff;
              ram_addr = first_q[Lb +: AddrW];
              ram_re   = ({1'b0, first_q} < EffFramesV);
              state_d  = S_ASCAN;
            end
          end
          bfa_pkg::KIND_FREE, bfa_pkg::KIND_MARK: begin
            // Reuse the allocate-side run bounds: cand holds the run start
            cand_d = {2'b00, req_q.run_start};
            set_d  = (req_q.kind == bfa_pkg::KIND_MARK);
            state_d = S_MRD;
            pos_d  = {2'b00, req_q.run_start};
          end
          default: ;
        endcase
      end
      S_ASCAN: begin
        if (sum >= count_q) begin
          // Run fits: record it and mark it used
          res_d   = '{found_frame: cand_q[15:0], status: bfa_pkg::STATUS_OK};
          set_d   = 1'b1;
          pos_d   = cand_q;
          hi_d    = hi_eff;
          state_d = (cand_q >= hi_eff) ? S_DONE : S_MRD;
        end else if (in_virt || (!any_used && (e_abs == lim_q))) begin
          res_d   = '{found_frame: '0, status: bfa_pkg::STATUS_NOMEM};
          state_d = S_DONE;
        end else begin
          if (any_used) begin
            run_d  = '0;
            pos_d  = base + PosW'(u_off) + PosW'(1);
            cand_d = base + PosW'(u_off) + PosW'(1);
          end else begin
            run_d = sum;
            pos_d = line_end;
          end
          ram_addr = pos_d[Lb +: AddrW];
          ram_re   = (pos_d[PosW-1:Lb] != pos_q[PosW-1:Lb]) && (pos_d < EffFramesV);
        end
      end
      S_MRD: begin
        ram_re  = 1'b1;
        state_d = S_MWR;
      end
      S_MWR: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | mark_m) : (ram_rdata & ~mark_m);
        pos_d     = line_end;
        state_d   = (line_end >= hi_q) ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Free and mark: clip the run to the stored map before the first line
    if (state_q == S_START &&
        (req_q.kind == bfa_pkg::KIND_FREE || req_q.kind == bfa_pkg::KIND_MARK)) begin
      hi_d = (({2'b00, req_q.run_start} + count_d) < EffFramesV) ?
             ({2'b00, req_q.run_start} + count_d) : EffFramesV;
      if ({2'b00, req_q.run_start} >= hi_d) begin
        state_d = S_DONE;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      first_q     <= '0;
      limit_q     <= 17'h10000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      first_q     <= first_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    pos_q   <= pos_d;
    cand_q  <= cand_d;
    run_q   <= run_d;
    count_q <= count_d;
    lim_q   <= lim_d;
    hi_q    <= hi_d;
    set_q   <= set_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // The scan never writes the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN) |-> !ram_we)
    else $error("map written during scan");

  // A marking pass only touches lines below the run end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MWR) |-> (pos_q < hi_q))
    else $error("marking beyond run end");

  // An open run is always shorter than the request while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN) |-> (run_q < count_q))
    else $error("scan kept a completed run");

  // A failed allocation reports frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.status && (out_data_o.found_frame != '0)))
    else $error("failed result carries a frame");

endmodule
